>>> rtl/core/urbf_pkg.sv
`timescale 1ns / 1ps

package urbf_pkg;

    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_RX    = 2'd2;

    localparam logic [31:0] OFF_TXDATA = 32'd0;
    localparam logic [31:0] OFF_RXDATA = 32'd4;
    localparam logic [31:0] OFF_TXCTRL = 32'd8;
    localparam logic [31:0] OFF_RXCTRL = 32'd12;
    localparam logic [31:0] OFF_IE     = 32'd16;
    localparam logic [31:0] OFF_IP     = 32'd20;
    localparam logic [31:0] OFF_DIV    = 32'd24;

    localparam logic [31:0] RD_FLAG = 32'h8000_0000;

    // at most this many bytes leave per bus write
    localparam int MAX_BURST = 8;
    localparam int BURST_W   = 4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_PREP,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] address;
        logic [31:0] write_data;
        logic [7:0]  rx_byte;
    } item_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        last;
        logic        overflow;
        logic        irq_txwm;
        logic        irq_rxwm;
    } result_t;

    typedef struct packed {
        logic       push;
        logic       pop;
        logic [7:0] wdata;
    } fifo_ctrl_t;

endpackage

>>> rtl/core/urbf_fifo.sv
`timescale 1ns / 1ps

module urbf_fifo #(
    parameter int DEPTH = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  urbf_pkg::fifo_ctrl_t       ctrl,
    output logic [$clog2(DEPTH+1)-1:0] fill,
    output logic [7:0]                 rdata
);
    import urbf_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);
    localparam int SW = FW + 1;

    logic [7:0]    queue_mem [DEPTH];
    logic [PW-1:0] head_reg;
    logic [PW-1:0] head_next;
    logic [FW-1:0] fill_reg;
    logic [FW-1:0] fill_next;
    logic [SW-1:0] tail_sum;
    logic [PW-1:0] tail;
    logic [7:0]    rdata_reg;

    always_comb
    begin
        tail_sum = SW'(head_reg) + SW'(fill_reg);
        if (tail_sum >= SW'(DEPTH))
        begin
            tail = PW'(tail_sum - SW'(DEPTH));
        end
        else
        begin
            tail = PW'(tail_sum);
        end
    end

    always_comb
    begin
        head_next = head_reg;
        if (ctrl.pop)
        begin
            if (head_reg == PW'(DEPTH - 1))
            begin
                head_next = '0;
            end
            else
            begin
                head_next = head_reg + PW'(1);
            end
        end
        fill_next = fill_reg + FW'(ctrl.push) - FW'(ctrl.pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            fill_reg <= fill_next;
        end
    end

    // read port looks ahead to the new head so a pop leaves the next word ready
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            queue_mem[tail] <= ctrl.wdata;
        end
        rdata_reg <= queue_mem[head_next];
    end

    assign fill  = fill_reg;
    assign rdata = rdata_reg;

endmodule

>>> rtl/core/uart_register_block_with_fifos.sv
`timescale 1ns / 1ps

// UART register file (txdata, rxdata, txctrl, rxctrl, ie, ip, div at word offsets
// 0..24 from the programmed base) with transmit and receive byte FIFOs held in
// synchronous RAMs. Pulse start while busy is low; the item is taken at that edge.
// Reads, receive-byte arrivals and writes that send nothing run through EXEC and give
// one result strobe. A write that sends bytes with txen set runs EXEC, PREP, then DRAIN
// for n bytes (n up to 8), one result per cycle; PREP is the RAM read of the FIFO
// head after the txdata write. Results are shown for one cycle only, so the
// receiver must take each strobe as it comes. The base address port is always ready.
module uart_register_block_with_fifos #(
    parameter int TX_DEPTH = 8,
    parameter int RX_DEPTH = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  urbf_pkg::item_t   item,
    output logic              busy,
    output logic              result_valid,
    output urbf_pkg::result_t result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [31:0]       cfg_data
);
    import urbf_pkg::*;

    localparam int TX_FW = $clog2(TX_DEPTH + 1);
    localparam int RX_FW = $clog2(RX_DEPTH + 1);
    localparam int TX_CW = (TX_FW > 3) ? TX_FW : 3;
    localparam int RX_CW = (RX_FW > 3) ? RX_FW : 3;
    localparam int BCW   = (TX_FW > BURST_W) ? TX_FW : BURST_W;

    state_t state_reg, state_next;

    item_t        item_reg;
    logic [31:0]  offset_reg;
    logic [31:0]  base_reg;
    logic         tx_en_reg;
    logic         stop_reg;
    logic [2:0]   tx_wm_reg;
    logic         rx_en_reg;
    logic [2:0]   rx_wm_reg;
    logic [1:0]   ie_reg;
    logic [1:0]   ip_reg;
    logic [1:0]   ip_next;
    logic [15:0]  div_reg;
    logic         ovf_reg;
    logic [BURST_W-1:0] burst_reg, burst_next;
    result_t      result_reg, result_next;
    logic         result_valid_reg, result_valid_next;

    fifo_ctrl_t        tx_ctrl, rx_ctrl;
    logic [TX_FW-1:0]  tx_fill;
    logic [RX_FW-1:0]  rx_fill;
    logic [7:0]        tx_rdata, rx_rdata;

    logic              accept;
    logic              is_rd, is_wr, is_rx;
    logic              tx_full, rx_full;
    logic              ovf;
    logic [31:0]       rdata;
    logic              tx_en_new;
    logic [2:0]        tx_wm_new, rx_wm_new;
    logic [1:0]        ie_new;
    logic [TX_FW-1:0]  tx_fill_w, tx_fill_end;
    logic [RX_FW-1:0]  rx_fill_end;
    logic [BCW-1:0]    burst_calc;

    urbf_fifo #(.DEPTH(TX_DEPTH)) u_tx_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (tx_ctrl),
        .fill  (tx_fill),
        .rdata (tx_rdata)
    );

    urbf_fifo #(.DEPTH(RX_DEPTH)) u_rx_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (rx_ctrl),
        .fill  (rx_fill),
        .rdata (rx_rdata)
    );

    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;

    assign is_rd   = (item_reg.mode == MODE_READ);
    assign is_wr   = (item_reg.mode == MODE_WRITE);
    assign is_rx   = (item_reg.mode == MODE_RX);
    assign tx_full = (tx_fill == TX_FW'(TX_DEPTH));
    assign rx_full = (rx_fill == RX_FW'(RX_DEPTH));

    // register read mux, values from before this item
    always_comb
    begin
        rdata = '0;
        if (is_rd)
        begin
            unique case (offset_reg)
                OFF_TXDATA: rdata = tx_full ? RD_FLAG : '0;
                OFF_RXDATA: rdata = (rx_fill != '0) ? {24'b0, rx_rdata} : RD_FLAG;
                OFF_TXCTRL: rdata = {13'b0, tx_wm_reg, 14'b0, stop_reg, tx_en_reg};
                OFF_RXCTRL: rdata = {13'b0, rx_wm_reg, 15'b0, rx_en_reg};
                OFF_IE:     rdata = {30'b0, ie_reg};
                OFF_IP:     rdata = {30'b0, ip_reg};
                OFF_DIV:    rdata = {16'b0, div_reg};
                default:    rdata = '0;
            endcase
        end
    end

    // execute-state datapath: FIFO moves (the tx pop in DRAIN), final fills and the new pending bits
    always_comb
    begin
        tx_ctrl       = '0;
        rx_ctrl       = '0;
        tx_ctrl.wdata = item_reg.write_data[7:0];
        rx_ctrl.wdata = item_reg.rx_byte;
        ovf           = 1'b0;
        tx_en_new     = tx_en_reg;
        tx_wm_new     = tx_wm_reg;
        rx_wm_new     = rx_wm_reg;
        ie_new        = ie_reg;

        if (state_reg == ST_EXEC)
        begin
            if (is_wr && offset_reg == OFF_TXDATA)
            begin
                tx_ctrl.push = !tx_full;
                ovf          = tx_full;
            end
            if (is_rx)
            begin
                rx_ctrl.push = !rx_full;
                ovf          = rx_full;
            end
            rx_ctrl.pop = is_rd && (offset_reg == OFF_RXDATA) && (rx_fill != '0);
            if (is_wr && offset_reg == OFF_TXCTRL)
            begin
                tx_en_new = item_reg.write_data[0];
                tx_wm_new = item_reg.write_data[18:16];
            end
            if (is_wr && offset_reg == OFF_RXCTRL)
            begin
                rx_wm_new = item_reg.write_data[18:16];
            end
            if (is_wr && offset_reg == OFF_IE)
            begin
                ie_new = item_reg.write_data[1:0];
            end
        end
        tx_ctrl.pop = (state_reg == ST_DRAIN);

        tx_fill_w = tx_fill + TX_FW'(tx_ctrl.push);
        if (!(is_wr && tx_en_new))
        begin
            burst_calc = '0;
        end
        else if (BCW'(tx_fill_w) > BCW'(MAX_BURST))
        begin
            burst_calc = BCW'(MAX_BURST);
        end
        else
        begin
            burst_calc = BCW'(tx_fill_w);
        end
        tx_fill_end = tx_fill_w - TX_FW'(burst_calc);
        rx_fill_end = rx_fill + RX_FW'(rx_ctrl.push) - RX_FW'(rx_ctrl.pop);

        ip_next[0] = ie_new[0] && (TX_CW'(tx_fill_end) < TX_CW'(tx_wm_new));
        ip_next[1] = ie_new[1] && (RX_CW'(rx_fill_end) > RX_CW'(rx_wm_new));
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = (burst_calc != '0) ? ST_PREP : ST_IDLE;
            end
            ST_PREP:
            begin
                state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (burst_reg == BURST_W'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        result_valid_next = 1'b0;
        result_next       = '0;
        burst_next        = burst_reg;
        unique case (state_reg)
            ST_EXEC:
            begin
                burst_next = BURST_W'(burst_calc);
                if (burst_calc == '0)
                begin
                    result_valid_next     = 1'b1;
                    result_next.read_data = rdata;
                    result_next.last      = 1'b1;
                    result_next.overflow  = ovf;
                    result_next.irq_txwm  = ip_next[0];
                    result_next.irq_rxwm  = ip_next[1];
                end
            end
            ST_DRAIN:
            begin
                burst_next            = burst_reg - BURST_W'(1);
                result_valid_next     = 1'b1;
                result_next.tx_valid  = 1'b1;
                result_next.tx_byte   = tx_rdata;
                result_next.last      = (burst_reg == BURST_W'(1));
                result_next.overflow  = ovf_reg;
                result_next.irq_txwm  = ip_reg[0];
                result_next.irq_rxwm  = ip_reg[1];
            end
            default:
            begin
                result_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
            burst_reg        <= '0;
            base_reg         <= '0;
            tx_en_reg        <= 1'b0;
            stop_reg         <= 1'b0;
            tx_wm_reg        <= '0;
            rx_en_reg        <= 1'b0;
            rx_wm_reg        <= '0;
            ie_reg           <= '0;
            ip_reg           <= '0;
            div_reg          <= '0;
            ovf_reg          <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
            burst_reg        <= burst_next;
            if (cfg_valid && cfg_ready)
            begin
                base_reg <= cfg_data;
            end
            if (state_reg == ST_EXEC)
            begin
                tx_en_reg <= tx_en_new;
                tx_wm_reg <= tx_wm_new;
                rx_wm_reg <= rx_wm_new;
                ie_reg    <= ie_new;
                ip_reg    <= ip_next;
                ovf_reg   <= ovf;
                if (is_wr && offset_reg == OFF_TXCTRL)
                begin
                    stop_reg <= item_reg.write_data[1];
                end
                if (is_wr && offset_reg == OFF_RXCTRL)
                begin
                    rx_en_reg <= item_reg.write_data[0];
                end
                if (is_wr && offset_reg == OFF_DIV)
                begin
                    div_reg <= item_reg.write_data[15:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg   <= item;
            offset_reg <= item.address - base_reg;
        end
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

>>> rtl/core/urbf_checker.sv
`timescale 1ns / 1ps

module urbf_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              busy,
    input logic              result_valid,
    input urbf_pkg::result_t result
);
    import urbf_pkg::*;

    // every word comes out of an item in flight
    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result word without an item in flight");

    a_plain_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.tx_valid |-> result.last)
        else $error("non-transmit word not marked last");

    // a burst runs without gaps until its last word
    a_burst_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last |=> result_valid && result.tx_valid)
        else $error("gap inside a transmit burst");

    a_last_frees_block: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last |-> !busy)
        else $error("still busy after the last word");

    a_tx_no_read_data: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.tx_valid |-> result.read_data == '0)
        else $error("read data on a transmit word");

endmodule

bind uart_register_block_with_fifos urbf_checker u_urbf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);

>>> tb/sv/uart_register_block_with_fifos_test.sv
`timescale 1ns / 1ps

module uart_register_block_with_fifos_test;

    import urbf_pkg::*;

    localparam int QDEPTH = 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RAND_PER_PHASE = 25;
    localparam logic [1:0] MODE_NONE = 2'd3;
    localparam logic [31:0] OFF_UNUSED = 32'd28;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    item_t item = '0;
    logic busy;
    logic result_valid;
    result_t result;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [31:0] cfg_data = '0;

    uart_register_block_with_fifos dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .item(item),
        .busy(busy),
        .result_valid(result_valid),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    // register file and FIFO shadow
    logic [31:0] uart_base = '0;
    logic [7:0] tx_mem [QDEPTH];
    logic [7:0] rx_mem [QDEPTH];
    int tx_cnt = 0;
    int tx_rd = 0;
    int rx_cnt = 0;
    int rx_rd = 0;
    bit tx_on = 1'b0;
    bit stop2 = 1'b0;
    bit [2:0] tx_lvl = '0;
    bit rx_on = 1'b0;
    bit [2:0] rx_lvl = '0;
    bit [1:0] irq_en = '0;
    bit [1:0] irq_pend = '0;
    bit [15:0] divisor = '0;

    result_t uart_responses[$];

    typedef struct {
        item_t   it;
        bit      typed;
        result_t want;
    } drow_t;

    drow_t plan[$];

    int fails = 0;
    int cycles = 0;
    int items_sent = 0;
    int words_checked = 0;
    int bytes_seen = 0;
    int overflows_seen = 0;
    bit calm = 1'b0;
    result_t want_w;
    logic [31:0] bases [4];

    // applies one item to the shadow and queues the words it should produce
    task automatic step_uart_regs(input item_t it);
        logic [31:0] off;
        logic [31:0] rd;
        logic [31:0] wd;
        bit ovf;
        logic [7:0] sent[$];
        int n;
        result_t w;
        off = it.address - uart_base;
        wd = it.write_data;
        rd = '0;
        ovf = 1'b0;
        case (it.mode)
            MODE_READ: begin
                case (off)
                    OFF_TXDATA: rd = (tx_cnt >= QDEPTH) ? RD_FLAG : '0;
                    OFF_RXDATA: begin
                        if (rx_cnt > 0)
                        begin
                            rd = {24'd0, rx_mem[rx_rd]};
                            rx_rd = (rx_rd + 1) % QDEPTH;
                            rx_cnt--;
                        end
                        else
                        begin
                            rd = RD_FLAG;
                        end
                    end
                    OFF_TXCTRL: rd = {13'd0, tx_lvl, 14'd0, stop2, tx_on};
                    OFF_RXCTRL: rd = {13'd0, rx_lvl, 15'd0, rx_on};
                    OFF_IE:     rd = {30'd0, irq_en};
                    OFF_IP:     rd = {30'd0, irq_pend};
                    OFF_DIV:    rd = {16'd0, divisor};
                    default:    rd = '0;
                endcase
            end
            MODE_WRITE: begin
                case (off)
                    OFF_TXDATA: begin
                        if (tx_cnt >= QDEPTH)
                        begin
                            ovf = 1'b1;
                        end
                        else
                        begin
                            tx_mem[(tx_rd + tx_cnt) % QDEPTH] = wd[7:0];
                            tx_cnt++;
                        end
                    end
                    OFF_TXCTRL: begin
                        tx_on = wd[0];
                        stop2 = wd[1];
                        tx_lvl = wd[18:16];
                    end
                    OFF_RXCTRL: begin
                        rx_on = wd[0];
                        rx_lvl = wd[18:16];
                    end
                    OFF_IE:  irq_en = wd[1:0];
                    OFF_DIV: divisor = wd[15:0];
                    default: ;
                endcase
                if (tx_on)
                begin
                    while (tx_cnt > 0 && sent.size() < MAX_BURST)
                    begin
                        sent.push_back(tx_mem[tx_rd]);
                        tx_rd = (tx_rd + 1) % QDEPTH;
                        tx_cnt--;
                    end
                end
            end
            MODE_RX: begin
                if (rx_cnt >= QDEPTH)
                begin
                    ovf = 1'b1;
                end
                else
                begin
                    rx_mem[(rx_rd + rx_cnt) % QDEPTH] = it.rx_byte;
                    rx_cnt++;
                end
            end
            default: ;
        endcase
        irq_pend[0] = irq_en[0] && (tx_cnt < tx_lvl);
        irq_pend[1] = irq_en[1] && (rx_cnt > rx_lvl);
        n = (sent.size() > 0) ? sent.size() : 1;
        for (int k = 0; k < n; k++)
        begin
            w.read_data = rd;
            w.tx_valid = (sent.size() > 0);
            w.tx_byte = (sent.size() > 0) ? sent[k] : 8'h00;
            w.last = (k == n - 1);
            w.overflow = ovf;
            w.irq_txwm = irq_pend[0];
            w.irq_rxwm = irq_pend[1];
            uart_responses.push_back(w);
        end
    endtask

    function automatic result_t plain_word(input logic [31:0] rd);
        result_t w;
        w = '0;
        w.read_data = rd;
        w.last = 1'b1;
        return w;
    endfunction

    function automatic void add_row(input logic [1:0] m, input logic [31:0] off,
                                    input logic [31:0] d, input logic [7:0] b,
                                    input bit typed, input result_t want);
        drow_t r;
        r.it.mode = m;
        r.it.address = off;
        r.it.write_data = d;
        r.it.rx_byte = b;
        r.typed = typed;
        r.want = want;
        plan.push_back(r);
    endfunction

    function automatic item_t random_item();
        item_t it;
        int r;
        it.mode = MODE_READ;
        it.address = uart_base + (32'($urandom_range(6)) << 2);   // any register word
        it.write_data = $urandom;
        it.rx_byte = 8'($urandom_range(255));
        r = $urandom_range(99);
        if (r < 22)
        begin
            it.mode = MODE_WRITE;
            it.address = uart_base + OFF_TXDATA;
        end
        else if (r < 36)
        begin
            it.mode = MODE_RX;
        end
        else if (r < 44)
        begin
            it.address = uart_base + OFF_RXDATA;
        end
        else if (r < 52)
        begin
            it.mode = MODE_WRITE;
            it.address = uart_base + OFF_TXCTRL;
            it.write_data[0] = ($urandom_range(99) < 35);
        end
        else if (r < 57)
        begin
            it.mode = MODE_WRITE;
            it.address = uart_base + OFF_RXCTRL;
        end
        else if (r < 62)
        begin
            it.mode = MODE_WRITE;
            it.address = uart_base + OFF_IE;
        end
        else if (r < 65)
        begin
            it.mode = MODE_WRITE;
            it.address = uart_base + OFF_DIV;
        end
        else if (r < 80)
        begin
            it.mode = MODE_READ;
        end
        else if (r < 86)
        begin
            it.mode = MODE_WRITE;
        end
        else if (r < 90)
        begin
            it.mode = MODE_NONE;
            it.address = $urandom;
        end
        else if (r < 95)
        begin
            it.address = $urandom;
        end
        else
        begin
            it.mode = MODE_WRITE;
            it.address = $urandom;
        end
        return it;
    endfunction

    task automatic issue(input item_t it, input bit typed, input result_t want);
        while (!calm && $urandom_range(99) < 14)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        item <= it;
        do @(posedge clk); while (busy);
        step_uart_regs(it);
        // typed rows always give a single word
        if (typed)
        begin
            uart_responses[uart_responses.size() - 1] = want;
        end
        items_sent++;
    endtask

    task automatic set_base(input logic [31:0] b);
        start <= 1'b0;
        while (uart_responses.size() != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
        while ($urandom_range(99) < 14)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= b;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        uart_base = b;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (uart_responses.size() == 0)
            begin
                fails++;
                if (fails <= 10)
                    $display("unexpected word: rd=%h txv=%b txb=%h last=%b ovf=%b irq=%b%b",
                             result.read_data, result.tx_valid, result.tx_byte, result.last,
                             result.overflow, result.irq_rxwm, result.irq_txwm);
            end
            else
            begin
                want_w = uart_responses.pop_front();
                words_checked++;
                if (result.tx_valid === 1'b1)
                    bytes_seen++;
                if (result.overflow === 1'b1)
                    overflows_seen++;
                if (result.read_data !== want_w.read_data || result.tx_valid !== want_w.tx_valid
                    || result.tx_byte !== want_w.tx_byte || result.last !== want_w.last
                    || result.overflow !== want_w.overflow
                    || result.irq_txwm !== want_w.irq_txwm
                    || result.irq_rxwm !== want_w.irq_rxwm)
                begin
                    fails++;
                    if (fails <= 10)
                        $display({"mismatch: want rd=%h txv=%b txb=%h last=%b ovf=%b irq=%b%b",
                                  " got rd=%h txv=%b txb=%h last=%b ovf=%b irq=%b%b"},
                                 want_w.read_data, want_w.tx_valid, want_w.tx_byte,
                                 want_w.last, want_w.overflow, want_w.irq_rxwm,
                                 want_w.irq_txwm, result.read_data, result.tx_valid,
                                 result.tx_byte, result.last, result.overflow,
                                 result.irq_rxwm, result.irq_txwm);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycles, uart_responses.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        // directed part runs at the reset base of zero
        add_row(MODE_READ, OFF_TXDATA, '0, 8'h00, 1'b1, plain_word('0));
        add_row(MODE_READ, OFF_RXDATA, '1, 8'hFF, 1'b1, plain_word(RD_FLAG));
        add_row(MODE_READ, OFF_UNUSED, $urandom, 8'h5A, 1'b1, plain_word('0));
        add_row(MODE_WRITE, OFF_DIV, 32'hFFFF_FFFF, 8'h00, 1'b1, plain_word('0));
        add_row(MODE_READ, OFF_DIV, '0, 8'h00, 1'b1, plain_word(32'h0000_FFFF));
        add_row(MODE_WRITE, OFF_IE, 32'hFFFF_FFFF, 8'h00, 1'b0, '0);
        // stop bits, top watermark, transmitter held off
        add_row(MODE_WRITE, OFF_TXCTRL, 32'h0007_0002, 8'h00, 1'b0, '0);
        // fill the tx FIFO, last one overflows
        for (int k = 0; k < QDEPTH + 1; k++)
            add_row(MODE_WRITE, OFF_TXDATA, (k == 0) ? 32'h0 : (k == 1) ? 32'hFFFF_FFFF : $urandom,
                    8'h00, 1'b0, '0);
        add_row(MODE_READ, OFF_TXDATA, '0, 8'h00, 1'b0, '0);
        for (int k = 0; k < QDEPTH + 1; k++)
            add_row(MODE_RX, $urandom, $urandom,
                    (k == 0) ? 8'h00 : (k == 1) ? 8'hFF : 8'($urandom_range(255)), 1'b0, '0);
        add_row(MODE_READ, OFF_RXDATA, '0, 8'h00, 1'b0, '0);
        add_row(MODE_WRITE, OFF_RXDATA, '1, 8'h00, 1'b0, '0);
        add_row(MODE_WRITE, OFF_IP, '1, 8'h00, 1'b0, '0);
        add_row(MODE_NONE, $urandom, $urandom, 8'hC3, 1'b0, '0);
        // enabling tx drains the full FIFO in one burst
        add_row(MODE_WRITE, OFF_TXCTRL, 32'hFFFF_FFFF, 8'h00, 1'b0, '0);
        add_row(MODE_WRITE, OFF_UNUSED, $urandom, 8'h00, 1'b0, '0);
        add_row(MODE_READ, OFF_RXCTRL, '0, 8'h00, 1'b0, '0);

        bases[0] = 32'hFFFF_FFFF;
        bases[1] = $urandom;
        bases[2] = 32'h0000_0000;
        bases[3] = $urandom;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            issue(plan[i].it, plan[i].typed, plan[i].want);

        for (int ph = 0; ph < 4; ph++)
        begin
            set_base(bases[ph]);
            for (int j = 0; j < RAND_PER_PHASE; j++)
            begin
                calm = (ph == 1 && j < 24);
                issue(random_item(), 1'b0, '0);
            end
        end
        calm = 1'b0;
        start <= 1'b0;

        while (uart_responses.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        fails += uart_responses.size();

        $display("%0d items over 5 base settings, %0d words checked", items_sent, words_checked);
        $display("%0d tx bytes seen, %0d overflow words, %0d failures",
                 bytes_seen, overflows_seen, fails);
        if (fails == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> uart_register_block_with_fifos.f
rtl/core/urbf_pkg.sv
rtl/core/urbf_fifo.sv
rtl/core/uart_register_block_with_fifos.sv
rtl/core/urbf_checker.sv
tb/sv/uart_register_block_with_fifos_test.sv
